>>> src/fjps_pkg.sv
// Shared types and token codes for the flat JSON pair scanner.
package fjps_pkg;

    // Token kinds carried in token_kind.
    localparam logic [2:0] KIND_KEY   = 3'd0;
    localparam logic [2:0] KIND_VALUE = 3'd1;
    localparam logic [2:0] KIND_PAIR  = 3'd2;
    localparam logic [2:0] KIND_EMPTY = 3'd3;
    localparam logic [2:0] KIND_DROP  = 3'd4;
    localparam logic [2:0] KIND_END   = 3'd5;

    // Characters the scanner reacts to.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] token_byte;
        logic       run_last;
    } out_item_t;

    // Up to three tokens caused by one input byte, in emission order:
    // the byte's own token, an end-of-text marker, the packet end.
    typedef struct packed {
        logic       tok_valid;
        logic [2:0] tok_kind;
        logic [7:0] tok_byte;
        logic       eot_valid;
        logic [2:0] eot_kind;
        logic       end_valid;
    } bundle_t;

endpackage

>>> src/fjps_front.sv
// Front end: classify each byte against the scan phase and build its token bundle.
module fjps_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  fjps_pkg::in_item_t item,
    output fjps_pkg::bundle_t  bundle,
    output logic               bundle_nonempty
);
    import fjps_pkg::*;

    typedef enum logic [2:0] {
        PH_BRACE,
        PH_SEEK,
        PH_KEY,
        PH_AFTER_KEY,
        PH_QV_FIRST,
        PH_QV,
        PH_BV,
        PH_DONE
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;

    // End-of-text marker for a phase; bit 3 flags that a marker exists.
    function automatic logic [3:0] eot_marker(input phase_t ph);
        logic [3:0] r;
        r = '0;
        unique case (ph)
            PH_KEY, PH_AFTER_KEY: r = {1'b1, KIND_DROP};
            PH_QV_FIRST, PH_QV:   r = {1'b1, KIND_EMPTY};
            PH_BV:                r = {1'b1, KIND_PAIR};
            default:              r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        logic [7:0] c;
        logic [3:0] m;
        c          = item.data_byte;
        m          = '0;
        bundle     = '0;
        phase_next = phase_reg;
        if (phase_reg != PH_DONE)
        begin
            if (c == CH_NUL)
            begin
                m                = eot_marker(phase_reg);
                bundle.eot_valid = m[3];
                bundle.eot_kind  = m[2:0];
                phase_next       = PH_DONE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_BRACE:
                        phase_next = (c == CH_LBRACE) ? PH_SEEK : PH_DONE;
                    PH_SEEK:
                    begin
                        if (c == CH_RBRACE)
                            phase_next = PH_DONE;
                        else if (c == CH_QUOTE)
                            phase_next = PH_KEY;
                    end
                    PH_KEY:
                    begin
                        if (c == CH_QUOTE)
                            phase_next = PH_AFTER_KEY;
                        else
                        begin
                            bundle.tok_valid = 1'b1;
                            bundle.tok_kind  = KIND_KEY;
                            bundle.tok_byte  = c;
                        end
                    end
                    PH_AFTER_KEY:
                    begin
                        if (c == CH_SPACE || c == CH_COLON || c == CH_TAB)
                            phase_next = PH_AFTER_KEY;
                        else if (c == CH_QUOTE)
                            phase_next = PH_QV_FIRST;
                        else if (c == CH_COMMA || c == CH_RBRACE)
                        begin
                            bundle.tok_valid = 1'b1;
                            bundle.tok_kind  = KIND_EMPTY;
                            phase_next       = (c == CH_COMMA) ? PH_SEEK : PH_DONE;
                        end
                        else
                        begin
                            bundle.tok_valid = 1'b1;
                            bundle.tok_kind  = KIND_VALUE;
                            bundle.tok_byte  = c;
                            phase_next       = PH_BV;
                        end
                    end
                    PH_QV_FIRST, PH_QV:
                    begin
                        bundle.tok_valid = 1'b1;
                        if (c == CH_QUOTE)
                        begin
                            bundle.tok_kind = (phase_reg == PH_QV_FIRST) ? KIND_EMPTY
                                                                         : KIND_PAIR;
                            phase_next      = PH_SEEK;
                        end
                        else
                        begin
                            bundle.tok_kind = KIND_VALUE;
                            bundle.tok_byte = c;
                            phase_next      = PH_QV;
                        end
                    end
                    PH_BV:
                    begin
                        bundle.tok_valid = 1'b1;
                        if (c == CH_COMMA || c == CH_SPACE)
                        begin
                            bundle.tok_kind = KIND_PAIR;
                            phase_next      = PH_SEEK;
                        end
                        else if (c == CH_RBRACE)
                        begin
                            bundle.tok_kind = KIND_PAIR;
                            phase_next      = PH_DONE;
                        end
                        else
                        begin
                            bundle.tok_kind = KIND_VALUE;
                            bundle.tok_byte = c;
                        end
                    end
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
        if (item.packet_last)
        begin
            // Close any open pair, then report the packet end and rearm.
            if (phase_next != PH_DONE)
            begin
                m                = eot_marker(phase_next);
                bundle.eot_valid = m[3];
                bundle.eot_kind  = m[2:0];
            end
            bundle.end_valid = 1'b1;
            phase_next       = PH_BRACE;
        end
    end

    assign bundle_nonempty = bundle.tok_valid | bundle.eot_valid | bundle.end_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_BRACE;
        else if (accept)
            phase_reg <= phase_next;
    end

endmodule

>>> src/fjps_queue.sv
// Bundle queue between the front end and the token serializer.
module fjps_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fjps_pkg::bundle_t push_data,
    input  logic              pop,
    output fjps_pkg::bundle_t head,
    output logic              not_empty,
    output logic              full
);
    import fjps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> src/fjps_back.sv
// Back end: serialize bundles into an output register; one token per unstalled cycle.
module fjps_back (
    input  logic                clk,
    input  logic                rst_n,
    input  fjps_pkg::bundle_t   head,
    input  logic                head_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output fjps_pkg::out_item_t out_item
);
    import fjps_pkg::*;

    logic [2:0] sent_reg;
    logic [2:0] sent_next;
    logic       valid_reg;
    logic       valid_next;
    out_item_t  item_reg;
    out_item_t  item_next;
    logic [2:0] pending;
    logic [2:0] pick;
    logic       advance;

    assign pending = {head.end_valid, head.eot_valid, head.tok_valid} & ~sent_reg;
    assign pick    = pending & (~pending + 3'd1);
    assign advance = head_valid && (!valid_reg || !out_stall);
    assign pop     = advance && ((pending & ~pick) == 3'b000);

    always_comb
    begin
        sent_next  = sent_reg;
        valid_next = valid_reg && out_stall;
        item_next  = item_reg;
        if (advance)
        begin
            valid_next         = 1'b1;
            item_next.run_last = pop;
            if (pick[0])
            begin
                item_next.token_kind = head.tok_kind;
                item_next.token_byte = head.tok_byte;
            end
            else if (pick[1])
            begin
                item_next.token_kind = head.eot_kind;
                item_next.token_byte = '0;
            end
            else
            begin
                item_next.token_kind = KIND_END;
                item_next.token_byte = '0;
            end
            // Clear the progress mask once the bundle leaves the queue.
            sent_next = pop ? 3'b000 : (sent_reg | pick);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg  <= sent_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> src/flat_json_pair_scanner.sv
// Top level of the flat JSON pair scanner: front end, bundle queue, token serializer.
//
// Bytes of a packet enter on the byte channel, one transaction per byte, with
// packet_last set on the final byte; the first byte must be '{' or the packet
// is ignored up to its end. Each byte yields zero to three tokens on the token
// channel (its own key/value byte or pair marker, an end-of-text marker, the
// packet-end token), with run_last set on the last token of that byte. The
// front end classifies a byte combinationally and pushes its token bundle into
// a QUEUE_DEPTH-entry queue; a byte is taken in every cycle in which that
// queue has room. The serializer drains one token per cycle into an output
// register while the token side does not stall; a token reaches the port
// through its queue slot and then that output register. Sustained rate is one
// byte per cycle while bytes yield at most one token each and the token side
// does not stall; a byte that yields more tokens holds the serializer until all
// of them are out, and the queue absorbs that until it fills and raises byte_stall.
// A zero byte ends the packet's text early. Reset returns the scan to waiting
// for the opening brace and empties the queue; no clearing pass is needed.
module flat_json_pair_scanner #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  fjps_pkg::in_item_t  byte_item,
    output logic                token_valid,
    input  logic                token_stall,
    output fjps_pkg::out_item_t token_item
);
    import fjps_pkg::*;

    bundle_t front_bundle;
    bundle_t queue_head;
    logic    front_nonempty;
    logic    byte_accept;
    logic    queue_full;
    logic    queue_not_empty;
    logic    queue_pop;

    // Take a byte whenever the queue has room; bytes with no tokens skip the queue.
    assign byte_stall  = queue_full;
    assign byte_accept = byte_valid && !queue_full;

    fjps_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (byte_accept),
        .item            (byte_item),
        .bundle          (front_bundle),
        .bundle_nonempty (front_nonempty)
    );

    fjps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (byte_accept && front_nonempty),
        .push_data (front_bundle),
        .pop       (queue_pop),
        .head      (queue_head),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    fjps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (queue_head),
        .head_valid (queue_not_empty),
        .pop        (queue_pop),
        .out_valid  (token_valid),
        .out_stall  (token_stall),
        .out_item   (token_item)
    );

endmodule

>>> src/fjps_checker.sv
// Port-level checks for the flat JSON pair scanner, bound to the top level.
module fjps_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_stall,
    input fjps_pkg::in_item_t  byte_item,
    input logic                token_valid,
    input logic                token_stall,
    input fjps_pkg::out_item_t token_item
);
    import fjps_pkg::*;

    // Hold a stalled byte transaction unchanged.
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
        else $error("stalled byte transaction changed");

    // Hold a stalled token transaction unchanged.
    a_token_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_item))
        else $error("stalled token transaction changed");

    // Drop nothing into markers: marker tokens carry a zero byte.
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !(token_item.token_kind == KIND_KEY ||
                         token_item.token_kind == KIND_VALUE)
        |-> token_item.token_byte == 8'h00)
        else $error("marker token with nonzero byte");

    // A zero byte ends the text, so key and value tokens never carry it.
    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_item.token_kind == KIND_KEY ||
                        token_item.token_kind == KIND_VALUE)
        |-> token_item.token_byte != 8'h00)
        else $error("key or value token carries a zero byte");

    // Packet end is always the final token of its byte.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_item.token_kind == KIND_END |-> token_item.run_last)
        else $error("packet end token without run_last");

endmodule

bind flat_json_pair_scanner fjps_checker u_fjps_checker (.*);

>>> dv/tb_flat_json_pair_scanner.sv
// Self-checking testbench for the flat JSON pair scanner: directed table, then random packets.
`timescale 1ns / 100ps

module tb_flat_json_pair_scanner;
    import fjps_pkg::*;

    // Newline is not in the package; it matters only right after a key,
    // where it starts a bare value instead of being skipped.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam int RANDOM_ITEMS   = 320;
    // Longest correct stretch with no transaction on either channel is bounded by
    // the sender gap, the queue and output registers, and the receiver stall.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_ROWS  = 27;

    // Scan phases of the predictor.
    typedef enum logic [2:0] {
        SCAN_BRACE,
        SCAN_SEEK,
        SCAN_KEY,
        SCAN_AFTER_KEY,
        SCAN_QV_EMPTY,
        SCAN_QV,
        SCAN_BARE,
        SCAN_DONE
    } scan_t;

    // Byte classes for the random packet builder.
    typedef enum {
        TXT_QUOTED,
        TXT_BARE_HEAD,
        TXT_BARE_TAIL
    } text_ctx_t;

    typedef enum {
        PKT_CLEAN,
        PKT_CUT,
        PKT_NUL,
        PKT_NOISE
    } pkt_shape_t;

    // One directed row. When fixed is set, the expected tokens are written
    // out in the row: n_tok tokens, byte0 on the first, markers carry zero.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_last;
        logic       fixed;
        logic [1:0] n_tok;
        logic [2:0] kind0;
        logic [2:0] kind1;
        logic [2:0] kind2;
        logic [7:0] byte0;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      token_valid;
    logic      token_stall;
    out_item_t token_item;

    scan_t     scan_state;
    out_item_t expected_tokens[$];
    logic [7:0] pkt_bytes[$];

    bit calm_send;
    int bytes_sent;
    int random_bytes;
    int packets_sent;
    int drain_pauses;
    int tokens_seen;
    int mismatches;
    int quiet_cycles;
    int kind_seen [6];

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // object with a repeated key: {"\xFF""v","\xFF" ,} then junk
        '{CH_LBRACE, 1'b0, 1'b1, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{8'hFF,     1'b0, 1'b1, 2'd1, KIND_KEY,   KIND_KEY,  KIND_KEY, 8'hFF},
        '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{8'h76,     1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_COMMA,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{8'hFF,     1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_SPACE,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_COMMA,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_RBRACE, 1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{8'h78,     1'b1, 1'b1, 2'd1, KIND_END,   KIND_KEY,  KIND_KEY, CH_NUL},
        // wrong first byte: ignored up to the final byte
        '{8'hFF,     1'b0, 1'b1, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_LBRACE, 1'b1, 1'b1, 2'd1, KIND_END,   KIND_KEY,  KIND_KEY, CH_NUL},
        // empty packet text: zero as the first and final byte
        '{CH_NUL,    1'b1, 1'b1, 2'd1, KIND_END,   KIND_KEY,  KIND_KEY, CH_NUL},
        // zero byte inside a key drops the key
        '{CH_LBRACE, 1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{8'h61,     1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_NUL,    1'b1, 1'b1, 2'd2, KIND_DROP,  KIND_END,  KIND_KEY, CH_NUL},
        // bare value cut by the final byte: three tokens from one byte
        '{CH_LBRACE, 1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{8'h62,     1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{CH_QUOTE,  1'b0, 1'b0, 2'd0, KIND_KEY,   KIND_KEY,  KIND_KEY, CH_NUL},
        '{8'h63,     1'b1, 1'b1, 2'd3, KIND_VALUE, KIND_PAIR, KIND_END, 8'h63}
    };

    flat_json_pair_scanner uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_item   (byte_item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Marker owed when the text stops in the current phase; 0 if none.
    function automatic bit truncation_marker(output logic [2:0] kind);
        kind = KIND_END;
        case (scan_state)
            SCAN_KEY, SCAN_AFTER_KEY:
            begin
                kind = KIND_DROP;
                return 1'b1;
            end
            SCAN_QV_EMPTY, SCAN_QV:
            begin
                kind = KIND_EMPTY;
                return 1'b1;
            end
            SCAN_BARE:
            begin
                kind = KIND_PAIR;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Advance the scan by one byte and return the tokens it yields, in order.
    function automatic int predict_tokens(input in_item_t it, output out_item_t [2:0] toks);
        int         n;
        logic [7:0] c;
        logic [2:0] mark;
        n    = 0;
        toks = '0;
        c    = it.data_byte;
        if (scan_state != SCAN_DONE)
        begin
            if (c == CH_NUL)
            begin
                // End of text: close whatever is open, then ignore the rest.
                if (truncation_marker(mark))
                begin
                    toks[n] = '{mark, CH_NUL, 1'b0};
                    n++;
                end
                scan_state = SCAN_DONE;
            end
            else
            begin
                case (scan_state)
                    SCAN_BRACE:
                        scan_state = (c == CH_LBRACE) ? SCAN_SEEK : SCAN_DONE;
                    SCAN_SEEK:
                    begin
                        if (c == CH_RBRACE)
                            scan_state = SCAN_DONE;
                        else if (c == CH_QUOTE)
                            scan_state = SCAN_KEY;
                    end
                    SCAN_KEY:
                    begin
                        if (c == CH_QUOTE)
                            scan_state = SCAN_AFTER_KEY;
                        else
                        begin
                            toks[n] = '{KIND_KEY, c, 1'b0};
                            n++;
                        end
                    end
                    SCAN_AFTER_KEY:
                    begin
                        if (c == CH_QUOTE)
                            scan_state = SCAN_QV_EMPTY;
                        else if (c == CH_COMMA || c == CH_RBRACE)
                        begin
                            toks[n] = '{KIND_EMPTY, CH_NUL, 1'b0};
                            n++;
                            scan_state = (c == CH_COMMA) ? SCAN_SEEK : SCAN_DONE;
                        end
                        else if (!(c == CH_SPACE || c == CH_COLON || c == CH_TAB))
                        begin
                            // Anything else, newline too, opens a bare value.
                            toks[n] = '{KIND_VALUE, c, 1'b0};
                            n++;
                            scan_state = SCAN_BARE;
                        end
                    end
                    SCAN_QV_EMPTY, SCAN_QV:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            toks[n] = '{(scan_state == SCAN_QV_EMPTY) ? KIND_EMPTY : KIND_PAIR,
                                        CH_NUL, 1'b0};
                            n++;
                            scan_state = SCAN_SEEK;
                        end
                        else
                        begin
                            toks[n] = '{KIND_VALUE, c, 1'b0};
                            n++;
                            scan_state = SCAN_QV;
                        end
                    end
                    SCAN_BARE:
                    begin
                        if (c == CH_COMMA || c == CH_SPACE || c == CH_RBRACE)
                        begin
                            toks[n] = '{KIND_PAIR, CH_NUL, 1'b0};
                            n++;
                            scan_state = (c == CH_RBRACE) ? SCAN_DONE : SCAN_SEEK;
                        end
                        else
                        begin
                            toks[n] = '{KIND_VALUE, c, 1'b0};
                            n++;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (it.packet_last)
        begin
            if (scan_state != SCAN_DONE && truncation_marker(mark))
            begin
                toks[n] = '{mark, CH_NUL, 1'b0};
                n++;
            end
            toks[n] = '{KIND_END, CH_NUL, 1'b0};
            n++;
            scan_state = SCAN_BRACE;
        end
        if (n > 0)
            toks[n - 1].run_last = 1'b1;
        return n;
    endfunction

    // Random nonzero byte that keeps the current field open.
    function automatic logic [7:0] rand_text_byte(input text_ctx_t ctx);
        logic [7:0] b;
        bit         bad;
        do
        begin
            b   = 8'($urandom_range(1, 255));
            bad = (b == CH_QUOTE && ctx != TXT_BARE_TAIL)
                || (ctx != TXT_QUOTED && (b == CH_COMMA || b == CH_SPACE || b == CH_RBRACE))
                || (ctx == TXT_BARE_HEAD && (b == CH_COLON || b == CH_TAB));
        end
        while (bad);
        return b;
    endfunction

    function automatic logic [7:0] filler_byte(input bit with_newline);
        case ($urandom_range(0, with_newline ? 3 : 2))
            0:       return CH_SPACE;
            1:       return CH_COLON;
            2:       return CH_TAB;
            default: return CH_NEWLINE;
        endcase
    endfunction

    // Build one packet into pkt_bytes: mostly well-formed objects with random
    // keys and values, some cut short or holding a zero, some pure noise.
    task automatic compose_packet();
        int         pick;
        int         pairs;
        int         len;
        pkt_shape_t shape;
        pkt_bytes.delete();
        pick  = $urandom_range(0, 9);
        shape = (pick < 7) ? PKT_CLEAN : (pick == 7) ? PKT_CUT
              : (pick == 8) ? PKT_NUL : PKT_NOISE;
        if (shape == PKT_NOISE)
        begin
            if ($urandom_range(0, 1) == 1)
                pkt_bytes.push_back(CH_LBRACE);
            repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            pkt_bytes.push_back(CH_LBRACE);
            pairs = $urandom_range(0, 3);
            for (int p = 0; p < pairs; p++)
            begin
                if (p > 0)
                    pkt_bytes.push_back(CH_COMMA);
                if ($urandom_range(0, 3) == 0)
                    pkt_bytes.push_back(filler_byte(1'b1));
                pkt_bytes.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 4)) pkt_bytes.push_back(rand_text_byte(TXT_QUOTED));
                pkt_bytes.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 2)) pkt_bytes.push_back(filler_byte(1'b0));
                case ($urandom_range(0, 2))
                    0:
                    begin
                        pkt_bytes.push_back(CH_QUOTE);
                        repeat ($urandom_range(0, 4))
                            pkt_bytes.push_back(rand_text_byte(TXT_QUOTED));
                        pkt_bytes.push_back(CH_QUOTE);
                    end
                    1:
                    begin
                        pkt_bytes.push_back(($urandom_range(0, 7) == 0) ? CH_NEWLINE
                                            : rand_text_byte(TXT_BARE_HEAD));
                        repeat ($urandom_range(0, 3))
                            pkt_bytes.push_back(rand_text_byte(TXT_BARE_TAIL));
                        if ($urandom_range(0, 3) == 0)
                            pkt_bytes.push_back(CH_SPACE);
                    end
                    default: ; // empty value: the next ',' or '}' closes the pair
                endcase
            end
            if ($urandom_range(0, 7) != 0)
                pkt_bytes.push_back(CH_RBRACE);
            repeat ($urandom_range(0, 1)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
            if (shape == PKT_CUT)
            begin
                len = $urandom_range(1, pkt_bytes.size());
                while (pkt_bytes.size() > len)
                    void'(pkt_bytes.pop_back());
            end
            else if (shape == PKT_NUL)
                pkt_bytes[$urandom_range(0, pkt_bytes.size() - 1)] = CH_NUL;
        end
    endtask

    // Offer one byte transaction, hold it through stalls, and queue its
    // expected tokens at the edge that accepts it.
    task automatic send_byte(input in_item_t it, input out_item_t [2:0] toks, input int n);
        int gap;
        gap = calm_send ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        do
            @(posedge clk);
        while (byte_stall !== 1'b0);
        for (int k = 0; k < n; k++)
            expected_tokens.push_back(toks[k]);
        bytes_sent++;
    endtask

    // Receiver: draw a random stall before each token, with calm stretches.
    initial
    begin
        int hold;
        bit calm;
        calm        = 1'b0;
        token_stall = 1'b0;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                calm = !calm;
            hold = calm ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                token_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            token_stall <= 1'b0;
            do
                @(posedge clk);
            while (token_valid !== 1'b1);
        end
    end

    // Check each accepted token against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && token_valid && !token_stall)
        begin
            tokens_seen++;
            if (token_item.token_kind <= KIND_END)
                kind_seen[token_item.token_kind]++;
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected token kind %0d byte %02h last %0b", $realtime,
                             token_item.token_kind, token_item.token_byte, token_item.run_last);
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (token_item.token_kind !== want.token_kind
                    || token_item.token_byte !== want.token_byte
                    || token_item.run_last !== want.run_last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: token %0d want kind %0d byte %02h last %0b, got %0d %02h %0b",
                                 $realtime, tokens_seen, want.token_kind, want.token_byte,
                                 want.run_last, token_item.token_kind, token_item.token_byte,
                                 token_item.run_last);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (token_valid && !token_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d tokens outstanding", $realtime,
                     quiet_cycles, expected_tokens.size());
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        in_item_t        it;
        out_item_t [2:0] toks;
        int              n;
        bit              paused_once;
        stim_row_t       row;

        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        byte_item    = '0;
        scan_state   = SCAN_BRACE;
        calm_send    = 1'b0;
        paused_once  = 1'b0;
        bytes_sent   = 0;
        random_bytes = 0;
        packets_sent = 0;
        drain_pauses = 0;
        tokens_seen  = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        foreach (kind_seen[k])
            kind_seen[k] = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: run every row through the predictor to keep the
        // scan phase in step, but use the written-out tokens where given.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            row            = directed_rows[r];
            it.data_byte   = row.data_byte;
            it.packet_last = row.packet_last;
            n = predict_tokens(it, toks);
            if (row.fixed)
            begin
                n       = int'(row.n_tok);
                toks[0] = '{row.kind0, row.byte0, 1'b0};
                toks[1] = '{row.kind1, CH_NUL, 1'b0};
                toks[2] = '{row.kind2, CH_NUL, 1'b0};
                if (n > 0)
                    toks[n - 1].run_last = 1'b1;
            end
            send_byte(it, toks, n);
            if (row.packet_last)
                packets_sent++;
        end

        // Random packets until the random byte count reaches its target;
        // bytes the block drops after the scan finished count too.
        while (random_bytes < RANDOM_ITEMS)
        begin
            compose_packet();
            calm_send = ($urandom_range(0, 3) == 0);
            if (!paused_once || $urandom_range(0, 5) == 0)
            begin
                // Hold off the sender until every queued token has drained.
                paused_once = 1'b1;
                drain_pauses++;
                byte_valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_tokens.size() != 0);
            end
            foreach (pkt_bytes[i])
            begin
                it.data_byte   = pkt_bytes[i];
                it.packet_last = (i == pkt_bytes.size() - 1);
                random_bytes++;
                n = predict_tokens(it, toks);
                send_byte(it, toks, n);
            end
            packets_sent++;
        end
        byte_valid <= 1'b0;

        // Drain, then linger so a stray extra token would still be caught.
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d packets, %0d bytes (%0d directed), %0d tokens, %0d drain pauses",
                 packets_sent, bytes_sent, DIRECTED_ROWS, tokens_seen, drain_pauses);
        $display("Token mix: key %0d value %0d pair %0d empty %0d drop %0d end %0d",
                 kind_seen[KIND_KEY], kind_seen[KIND_VALUE], kind_seen[KIND_PAIR],
                 kind_seen[KIND_EMPTY], kind_seen[KIND_DROP], kind_seen[KIND_END]);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
src/fjps_pkg.sv
src/fjps_front.sv
src/fjps_queue.sv
src/fjps_back.sv
src/flat_json_pair_scanner.sv
src/fjps_checker.sv
dv/tb_flat_json_pair_scanner.sv
